FILE: hdl/qsvp_pkg.sv
// Shared widths and codes of the quintic segment velocity planner.
package qsvp_pkg;

	// signed magnitude range of the wide intermediates
	localparam int MAG_W  = 64;
	// divisor width: twice a 32-bit duration
	localparam int DIV_W  = 33;
	// width of a time operand and of the stream words
	localparam int TIME_W = 32;

	typedef logic [0:0] reg_index_t;

	localparam reg_index_t REG_TIMER_RATE   = 1'b0;
	localparam reg_index_t REG_MIN_VELOCITY = 1'b1;

	localparam logic KIND_SEGMENT = 1'b0;
	localparam logic KIND_SAMPLE  = 1'b1;

endpackage

FILE: hdl/quintic_segment_velocity_planner_core.sv
// Top level of the quintic segment velocity planner: sequencer, datapath and stream ports.

// The block takes one item per s_* transfer and returns exactly one result per item on m_*.
// A segment item (tuser 0) fits the quintic coefficients a3, a4 and a5 from the step
// distance, the end velocity and acceleration left by the previous segment and the new
// targets, stores the targets as the next end state, and returns the start velocity, the
// step count, the step timer period timer_rate * 2^FRAC_BITS / max(|v0|, min_velocity)
// and half of it as the compare value. A sample item (tuser 1) evaluates the velocity
// polynomial at sample_time by Horner's rule. Every intermediate saturates to the signed
// COEFF_WIDTH range and the velocity to 32 bits; any clamp raises the overflow bit.
// One item is in work at a time. A segment runs 13 divisions on one bit-serial divider
// plus 6 saturating adds; a sample runs 4 multiplies on one bit-serial multiplier. The
// next item is taken as soon as the current one has moved into the output register,
// even while that result waits.
// Configuration writes are accepted in every cycle and must only happen while idle.
module quintic_segment_velocity_planner_core #(
	parameter int FRAC_BITS   = 16,
	parameter int COEFF_WIDTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	// in: current_position, target_position, target_velocity, target_acceleration,
	//     segment_duration, sample_time (32 bits each, from bit 0 up)
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,
	// in: kind
	input  logic [0:0]   s_tuser,
	// out: velocity(32), step_count(32), timer_period(32), timer_compare(31),
	//      overflow(1), from bit 0 up
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,
	// out: result_kind
	output logic [0:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int F    = FRAC_BITS;
	localparam int CW   = COEFF_WIDTH;
	localparam int MW   = qsvp_pkg::MAG_W;
	localparam int DVW  = qsvp_pkg::DIV_W;
	localparam int TW   = qsvp_pkg::TIME_W;
	localparam int QDW  = MW + F;
	localparam int PW   = CW + TW;
	localparam int SATW = MW + TW;
	localparam int LW   = MW + 4;

	localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ISSUE = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	// dividend sources
	localparam logic [2:0] XS_X    = 3'd0;
	localparam logic [2:0] XS_H20  = 3'd1;
	localparam logic [2:0] XS_H30  = 3'd2;
	localparam logic [2:0] XS_H12  = 3'd3;
	localparam logic [2:0] XS_RATE = 3'd4;

	// divisor sources
	localparam logic [1:0] DS_T  = 2'd0;
	localparam logic [1:0] DS_T2 = 2'd1;
	localparam logic [1:0] DS_VC = 2'd2;

	// quotient destinations
	localparam logic [2:0] DST_X   = 3'd0;
	localparam logic [2:0] DST_A3  = 3'd1;
	localparam logic [2:0] DST_A4  = 3'd2;
	localparam logic [2:0] DST_A5  = 3'd3;
	localparam logic [2:0] DST_PER = 3'd4;

	localparam logic [4:0] SMP_LAST = 5'd4;

	// ---------------------------------------------------------------- helpers
	// clamp a wide two's complement value into the coefficient range; top bit flags a clamp
	function automatic logic [CW:0] clamp_cw(input logic [LW-1:0] v);
		logic          ov;
		logic [CW-1:0] r;
		ov = !((&v[LW-1:CW-1]) || !(|v[LW-1:CW-1]));
		r  = ov ? (v[LW-1] ? CMIN : CMAX) : v[CW-1:0];
		return {ov, r};
	endfunction

	function automatic logic [CW:0] sadd(input logic [CW-1:0] a, input logic [MW-1:0] b);
		return clamp_cw(LW'($signed(a)) + LW'($signed(b)));
	endfunction

	// multiply by a small constant through shifts
	function automatic logic [CW:0] smulk(input logic [CW-1:0] x, input logic [2:0] k);
		logic [LW-1:0] xe;
		xe = LW'($signed(x));
		return clamp_cw((k[2] ? (xe << 2) : '0) + (k[1] ? (xe << 1) : '0) + (k[0] ? xe : '0));
	endfunction

	// apply the sign to an unsigned magnitude and saturate to the coefficient range
	function automatic logic [CW:0] sat_mag(input logic neg, input logic [SATW-1:0] q);
		logic          ov;
		logic [CW-1:0] r;
		ov = (|q[SATW-1:CW]) || (q[CW-1] && (!neg || (|q[CW-2:0])));
		if (ov)
			r = neg ? CMIN : CMAX;
		else
			r = neg ? (~q[CW-1:0] + 1'b1) : q[CW-1:0];
		return {ov, r};
	endfunction

	function automatic logic [32:0] clamp32(input logic [CW-1:0] v);
		logic        ov;
		logic [31:0] r;
		ov = !((&v[CW-1:31]) || !(|v[CW-1:31]));
		r  = ov ? (v[CW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF) : v[31:0];
		return {ov, r};
	endfunction

	// ---------------------------------------------------------------- registers
	logic [2:0]  state_q;
	logic [4:0]  step_q;
	logic        m_valid_q;

	logic [31:0] timer_rate_q;
	logic [31:0] min_vel_q;

	// profile state
	logic [31:0]   sv_q;
	logic [31:0]   hsa_q;
	logic [CW-1:0] a3_q;
	logic [CW-1:0] a4_q;
	logic [CW-1:0] a5_q;
	logic [31:0]   ev_q;
	logic [31:0]   ea_q;

	// item in work
	logic          kind_q;
	logic [32:0]   dist_q;
	logic [31:0]   v1_q;
	logic [31:0]   acc1_q;
	logic [31:0]   dur_q;
	logic [31:0]   t_q;
	logic [CW-1:0] x_q;
	logic          neg_q;
	logic          ovf_q;
	logic [31:0]   res_vel_q;
	logic [31:0]   per_q;

	// output register
	logic        out_kind_q;
	logic [31:0] out_vel_q;
	logic [31:0] out_steps_q;
	logic [31:0] out_per_q;
	logic        out_ovf_q;

	// ---------------------------------------------------------------- segment terms
	logic [MW-1:0] hq, h20, h30, h12;
	logic [MW-1:0] v1e, v0e, a1e, a0e, vsum;
	logic [MW-1:0] b1, b2, b3, c1, c2, c3;

	always_comb begin
		hq   = MW'($signed(dist_q)) << F;
		h20  = (hq << 4) + (hq << 2);
		h30  = ~((hq << 5) - (hq << 1)) + 1'b1;
		h12  = (hq << 3) + (hq << 2);
		v1e  = MW'($signed(v1_q));
		v0e  = MW'($signed(ev_q));
		a1e  = MW'($signed(acc1_q));
		a0e  = MW'($signed(ea_q));
		vsum = v1e + v0e;
		b1   = ~((v1e << 3) + (v0e << 3) + (v0e << 2)) + 1'b1;
		b2   = (v1e << 4) - (v1e << 1) + (v0e << 4);
		b3   = ~((vsum << 2) + (vsum << 1)) + 1'b1;
		c1   = a1e - ((a0e << 1) + a0e);
		c2   = (a0e << 1) + a0e - (a1e << 1);
		c3   = a1e - a0e;
	end

	// ---------------------------------------------------------------- segment program
	logic          op_div;
	logic [2:0]    xsrc;
	logic [1:0]    dsel;
	logic [2:0]    dst;
	logic [MW-1:0] addend;

	always_comb begin
		op_div = 1'b1;
		xsrc   = XS_X;
		dsel   = DS_T;
		dst    = DST_X;
		addend = '0;
		unique case (step_q)
			5'd0:  xsrc = XS_H20;
			5'd1:  begin op_div = 1'b0; addend = b1; end
			5'd2:  ;
			5'd3:  begin op_div = 1'b0; addend = c1; end
			5'd4:  begin dsel = DS_T2; dst = DST_A3; end
			5'd5:  xsrc = XS_H30;
			5'd6:  begin op_div = 1'b0; addend = b2; end
			5'd7:  ;
			5'd8:  begin op_div = 1'b0; addend = c2; end
			5'd9:  ;
			5'd10: begin dsel = DS_T2; dst = DST_A4; end
			5'd11: xsrc = XS_H12;
			5'd12: begin op_div = 1'b0; addend = b3; end
			5'd13: ;
			5'd14: begin op_div = 1'b0; addend = c3; end
			5'd15: ;
			5'd16: ;
			5'd17: begin dsel = DS_T2; dst = DST_A5; end
			5'd18: begin xsrc = XS_RATE; dsel = DS_VC; dst = DST_PER; end
			default: begin op_div = 1'b0; end
		endcase
	end

	// ---------------------------------------------------------------- divider operands
	logic [MW-1:0]  div_x;
	logic           div_neg;
	logic [MW-1:0]  div_mag;
	logic [31:0]    tfix;
	logic [31:0]    vabs;
	logic [31:0]    vmin;
	logic [31:0]    vc;
	logic [DVW-1:0] div_dvs;

	always_comb begin
		case (xsrc)
			XS_H20:  div_x = h20;
			XS_H30:  div_x = h30;
			XS_H12:  div_x = h12;
			XS_RATE: div_x = MW'(timer_rate_q);
			default: div_x = MW'($signed(x_q));
		endcase
		div_neg = div_x[MW-1];
		div_mag = div_neg ? (~div_x + 1'b1) : div_x;

		// zero duration and zero clamp count as one LSB
		tfix = (dur_q == '0) ? 32'd1 : dur_q;
		vabs = ev_q[31] ? (~ev_q + 1'b1) : ev_q;
		vmin = (min_vel_q == '0) ? 32'd1 : min_vel_q;
		vc   = (vabs > vmin) ? vabs : vmin;
		case (dsel)
			DS_T2:   div_dvs = {tfix, 1'b0};
			DS_VC:   div_dvs = {1'b0, vc};
			default: div_dvs = {1'b0, tfix};
		endcase
	end

	// ---------------------------------------------------------------- units
	logic           div_start, div_done;
	logic [QDW-1:0] div_quot;
	logic           mul_start, mul_done;
	logic [PW-1:0]  mul_prod;
	logic [CW-1:0]  mul_mag;

	assign mul_mag = x_q[CW-1] ? (~x_q + 1'b1) : x_q;

	qsvp_serial_div #(
		.FRAC_BITS(F)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_mag),
		.divisor (div_dvs),
		.done    (div_done),
		.quotient(div_quot)
	);

	qsvp_serial_mul #(
		.COEFF_WIDTH(CW)
	) u_mul (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (mul_start),
		.multiplicand(mul_mag),
		.multiplier  (t_q),
		.done        (mul_done),
		.product     (mul_prod)
	);

	// ---------------------------------------------------------------- results
	logic [CW:0]   add_r;
	logic [CW:0]   div_r;
	logic          per_ov;
	logic [31:0]   per_val;
	logic [CW:0]   k5_r;
	logic [CW:0]   mul_r;
	logic [CW:0]   k_r;
	logic [MW-1:0] term;
	logic          term_ov;
	logic [CW:0]   mres;
	logic [32:0]   vfin;
	logic [31:0]   dist_abs;

	always_comb begin
		add_r   = sadd(x_q, addend);
		div_r   = sat_mag(neg_q, SATW'(div_quot));
		per_ov  = |div_quot[QDW-1:32];
		per_val = per_ov ? 32'hFFFF_FFFF : div_quot[31:0];
		k5_r    = smulk(a5_q, 3'd5);
		mul_r   = sat_mag(neg_q, SATW'(mul_prod[PW-1:F]));

		// Horner terms: 4*a4, 3*a3, 2*a2, a1
		k_r = '0;
		case (step_q)
			5'd1:    k_r = smulk(a4_q, 3'd4);
			5'd2:    k_r = smulk(a3_q, 3'd3);
			default: k_r = '0;
		endcase
		case (step_q)
			5'd1, 5'd2: begin
				term    = MW'($signed(k_r[CW-1:0]));
				term_ov = k_r[CW];
			end
			5'd3: begin
				term    = MW'($signed(hsa_q)) << 1;
				term_ov = 1'b0;
			end
			default: begin
				term    = MW'($signed(sv_q));
				term_ov = 1'b0;
			end
		endcase
		mres     = sadd(mul_r[CW-1:0], term);
		vfin     = clamp32(mres[CW-1:0]);
		dist_abs = dist_q[32] ? 32'(~dist_q + 1'b1) : dist_q[31:0];
	end

	// ---------------------------------------------------------------- events
	logic acc_in, issue, seg_add, smp_init, div_fin, mul_fin, out_load, mul_last;

	assign acc_in    = s_tvalid && s_tready;
	assign issue     = (state_q == ST_ISSUE);
	assign seg_add   = issue && (kind_q == qsvp_pkg::KIND_SEGMENT) && !op_div;
	assign div_start = issue && (kind_q == qsvp_pkg::KIND_SEGMENT) && op_div;
	assign smp_init  = issue && (kind_q == qsvp_pkg::KIND_SAMPLE) && (step_q == '0);
	assign mul_start = issue && (kind_q == qsvp_pkg::KIND_SAMPLE) && (step_q != '0);
	assign div_fin   = (state_q == ST_DIV) && div_done;
	assign mul_fin   = (state_q == ST_MUL) && mul_done;
	assign mul_last  = (step_q == SMP_LAST);
	assign out_load  = (state_q == ST_DONE) && (!m_valid_q || m_tready);

	// ---------------------------------------------------------------- control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			m_valid_q    <= 1'b0;
			timer_rate_q <= 32'd1000000;
			min_vel_q    <= 32'd65536;
			sv_q         <= '0;
			hsa_q        <= '0;
			a3_q         <= '0;
			a4_q         <= '0;
			a5_q         <= '0;
			ev_q         <= '0;
			ea_q         <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					qsvp_pkg::REG_TIMER_RATE:   timer_rate_q <= cfg_data;
					qsvp_pkg::REG_MIN_VELOCITY: min_vel_q    <= cfg_data;
				endcase
			end

			// raise valid on a new result, drop a delivered one
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						step_q  <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (seg_add || smp_init)
						step_q <= step_q + 1'b1;
					else if (div_start)
						state_q <= ST_DIV;
					else if (mul_start)
						state_q <= ST_MUL;
				end
				ST_DIV: begin
					if (div_fin) begin
						if (dst == DST_PER) begin
							// commit the new end state
							sv_q    <= ev_q;
							hsa_q   <= 32'($signed(ea_q + {31'd0, ea_q[31]}) >>> 1);
							ev_q    <= v1_q;
							ea_q    <= acc1_q;
							state_q <= ST_DONE;
						end else begin
							if (dst == DST_A3)
								a3_q <= div_r[CW-1:0];
							if (dst == DST_A4)
								a4_q <= div_r[CW-1:0];
							if (dst == DST_A5)
								a5_q <= div_r[CW-1:0];
							step_q  <= step_q + 1'b1;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_MUL: begin
					if (mul_fin) begin
						if (mul_last) begin
							state_q <= ST_DONE;
						end else begin
							step_q  <= step_q + 1'b1;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		if (acc_in) begin
			kind_q <= s_tuser[0];
			dist_q <= 33'($signed(s_tdata[63:32])) - 33'($signed(s_tdata[31:0]));
			v1_q   <= s_tdata[95:64];
			acc1_q <= s_tdata[127:96];
			dur_q  <= s_tdata[159:128];
			t_q    <= s_tdata[191:160];
			ovf_q  <= 1'b0;
			per_q  <= '0;
		end
		if (seg_add) begin
			x_q   <= add_r[CW-1:0];
			ovf_q <= ovf_q | add_r[CW];
		end
		if (div_start)
			neg_q <= div_neg;
		if (mul_start)
			neg_q <= x_q[CW-1];
		if (div_fin) begin
			if (dst == DST_PER) begin
				per_q     <= per_val;
				res_vel_q <= ev_q;
				ovf_q     <= ovf_q | per_ov;
			end else begin
				x_q   <= div_r[CW-1:0];
				ovf_q <= ovf_q | div_r[CW];
			end
		end
		if (smp_init) begin
			x_q   <= k5_r[CW-1:0];
			ovf_q <= ovf_q | k5_r[CW];
		end
		if (mul_fin) begin
			x_q       <= mres[CW-1:0];
			res_vel_q <= vfin[31:0];
			ovf_q     <= ovf_q | mul_r[CW] | term_ov | mres[CW] | (mul_last & vfin[32]);
		end
		if (out_load) begin
			out_kind_q  <= kind_q;
			out_vel_q   <= res_vel_q;
			out_steps_q <= (kind_q == qsvp_pkg::KIND_SAMPLE) ? 32'd0 : dist_abs;
			out_per_q   <= per_q;
			out_ovf_q   <= ovf_q;
		end
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tuser   = out_kind_q;
	assign m_tdata   = {out_ovf_q, out_per_q[31:1], out_per_q, out_steps_q, out_vel_q};

	// ---------------------------------------------------------------- checks
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside its wait state");

	a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_MUL))
		else $error("multiplier finished outside its wait state");

	a_mul_only_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (kind_q == qsvp_pkg::KIND_SAMPLE))
		else $error("multiplier used by a segment item");

	a_div_launch: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> ((state_q == ST_DIV) && !div_done))
		else $error("division launch did not enter the wait state");

endmodule

FILE: hdl/qsvp_serial_div.sv
// Radix-2 restoring divider: (dividend * 2^FRAC_BITS) / divisor, one quotient bit per cycle.
module qsvp_serial_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	input  logic [qsvp_pkg::MAG_W-1:0]                dividend,
	input  logic [qsvp_pkg::DIV_W-1:0]                divisor,
	output logic                                      done,
	output logic [qsvp_pkg::MAG_W+FRAC_BITS-1:0]      quotient
);

	localparam int QW   = qsvp_pkg::MAG_W + FRAC_BITS;
	localparam int DVW  = qsvp_pkg::DIV_W;
	localparam int CNTW = $clog2(QW + 1);

	logic [QW-1:0]   shreg_q;
	logic [DVW-1:0]  rem_q;
	logic [DVW-1:0]  dvs_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [DVW:0] trial;
	logic [DVW:0] diff;
	logic         ge;

	assign trial = {rem_q, shreg_q[QW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = !diff[DVW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift the dividend out at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			shreg_q <= {dividend, {FRAC_BITS{1'b0}}};
			rem_q   <= '0;
			dvs_q   <= divisor;
		end else if (busy_q) begin
			shreg_q <= {shreg_q[QW-2:0], ge};
			rem_q   <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = shreg_q;

endmodule

FILE: hdl/qsvp_serial_mul.sv
// Shift-add multiplier: magnitude times a 32-bit time, one multiplier bit per cycle.
module qsvp_serial_mul #(
	parameter int COEFF_WIDTH = 64
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic [COEFF_WIDTH-1:0]                   multiplicand,
	input  logic [qsvp_pkg::TIME_W-1:0]              multiplier,
	output logic                                     done,
	output logic [COEFF_WIDTH+qsvp_pkg::TIME_W-1:0]  product
);

	localparam int CW   = COEFF_WIDTH;
	localparam int TW   = qsvp_pkg::TIME_W;
	localparam int CNTW = $clog2(TW + 1);

	logic [CW-1:0]   hi_q;
	logic [TW-1:0]   lo_q;
	logic [CW-1:0]   mcand_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [CW:0] sum;

	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(TW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q    <= '0;
			lo_q    <= multiplier;
			mcand_q <= multiplicand;
		end else if (busy_q) begin
			hi_q <= sum[CW:1];
			lo_q <= {sum[0], lo_q[TW-1:1]};
		end
	end

	assign done    = done_q;
	assign product = {hi_q, lo_q};

endmodule

FILE: sim/qsvp_checker.sv
// Scoreboard of the quintic segment velocity planner: predicts every result and compares it.
`timescale 1ns / 100ps

module qsvp_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [191:0] s_tdata,
	input  logic [0:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,
	input  logic [0:0]   m_tuser,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output int           fail_count,
	output int           pending,
	output int           n_segments,
	output int           n_samples,
	output int           n_saturated
);

	localparam int FRAC = 16;
	localparam longint CMAX = 64'sh7fff_ffff_ffff_ffff;
	localparam longint CMIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic        kind;
		logic [31:0] velocity;
		logic [31:0] steps;
		logic [31:0] period;
		logic [30:0] compare;
		logic        sat;
	} plan_result_t;

	plan_result_t result_q[$];

	// planner state and configuration
	logic [31:0] rate_hz, vel_floor;
	int          v_start, half_acc, v_end, acc_end;
	longint      c3, c4, c5;
	logic        sat_hit;

	function automatic longint signed_of(logic neg, logic [63:0] q);
		return neg ? longint'(-q) : longint'(q);
	endfunction

	// x * 2^F / d, truncated toward zero, saturating
	function automatic longint div_fx(longint x, logic [63:0] d);
		logic        neg;
		logic [63:0] m, lim, q1, r, q;
		neg = x < 0;
		m   = neg ? 64'(-x) : 64'(x);
		lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		q1  = m / d;
		r   = m % d;
		if (q1 > (lim >> FRAC)) begin
			sat_hit = 1'b1;
			return signed_of(neg, lim);
		end
		q = (q1 << FRAC) + ((r << FRAC) / d);
		if (q > lim) begin
			sat_hit = 1'b1;
			q = lim;
		end
		return signed_of(neg, q);
	endfunction

	// x * t / 2^F, truncated toward zero, saturating
	function automatic longint mul_fx(longint x, logic [63:0] t);
		logic        neg;
		logic [63:0] m, lim, phi, plo, q;
		neg = x < 0;
		m   = neg ? 64'(-x) : 64'(x);
		lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		phi = (m >> 32) * t;
		plo = (m & 64'hffff_ffff) * t;
		if (phi > (lim >> (32 - FRAC))) begin
			sat_hit = 1'b1;
			return signed_of(neg, lim);
		end
		q = (phi << (32 - FRAC)) + (plo >> FRAC);
		if (q > lim) begin
			sat_hit = 1'b1;
			q = lim;
		end
		return signed_of(neg, q);
	endfunction

	function automatic longint add_sat(longint a, longint b);
		logic signed [64:0] ea, eb, s;
		ea = a;
		eb = b;
		s  = ea + eb;
		if (s > CMAX) begin
			sat_hit = 1'b1;
			return CMAX;
		end
		if (s < CMIN) begin
			sat_hit = 1'b1;
			return CMIN;
		end
		return longint'(s);
	endfunction

	function automatic longint scale_sat(longint x, int k);
		logic signed [66:0] ex, p;
		ex = x;
		p  = ex * k;
		if (p > CMAX) begin
			sat_hit = 1'b1;
			return CMAX;
		end
		if (p < CMIN) begin
			sat_hit = 1'b1;
			return CMIN;
		end
		return longint'(p);
	endfunction

	// fit the new segment, advance the end state and derive the step timer
	function automatic plan_result_t plan_segment(logic [191:0] d);
		plan_result_t res;
		int          cur, tgt, v1, a1;
		longint      delta, hq, v0, a0, x;
		logic [63:0] dur, vabs, vc, per;
		cur  = d[31:0];
		tgt  = d[63:32];
		v1   = d[95:64];
		a1   = d[127:96];
		dur  = {32'd0, d[159:128]};
		if (dur == 0)
			dur = 1;
		v0   = v_end;
		a0   = acc_end;
		delta = longint'(tgt) - longint'(cur);
		hq   = delta * 65536;
		sat_hit = 1'b0;

		x  = div_fx(20 * hq, dur);
		x  = add_sat(x, -(8 * longint'(v1) + 12 * v0));
		x  = div_fx(x, dur);
		x  = add_sat(x, -(3 * a0 - longint'(a1)));
		c3 = div_fx(x, 2 * dur);

		x  = div_fx(-30 * hq, dur);
		x  = add_sat(x, 14 * longint'(v1) + 16 * v0);
		x  = div_fx(x, dur);
		x  = add_sat(x, 3 * a0 - 2 * longint'(a1));
		x  = div_fx(x, dur);
		c4 = div_fx(x, 2 * dur);

		x  = div_fx(12 * hq, dur);
		x  = add_sat(x, -(6 * (longint'(v1) + v0)));
		x  = div_fx(x, dur);
		x  = add_sat(x, longint'(a1) - a0);
		x  = div_fx(x, dur);
		x  = div_fx(x, dur);
		c5 = div_fx(x, 2 * dur);

		v_start  = v_end;
		half_acc = acc_end / 2;
		v_end    = v1;
		acc_end  = a1;

		vabs = v_start < 0 ? 64'(-longint'(v_start)) : 64'(longint'(v_start));
		vc   = (vel_floor == 0) ? 64'd1 : {32'd0, vel_floor};
		if (vabs > vc)
			vc = vabs;
		per = {16'd0, rate_hz, 16'd0} / vc;
		if (per > 64'hffff_ffff) begin
			per = 64'hffff_ffff;
			sat_hit = 1'b1;
		end
		res.kind     = qsvp_pkg::KIND_SEGMENT;
		res.velocity = v_start;
		res.steps    = delta < 0 ? 32'(-delta) : 32'(delta);
		res.period   = per[31:0];
		res.compare  = per[31:1];
		res.sat      = sat_hit;
		return res;
	endfunction

	// Horner evaluation of v(t)
	function automatic plan_result_t eval_velocity(logic [31:0] ts);
		plan_result_t res;
		logic [63:0]  t;
		longint       acc;
		t = {32'd0, ts};
		sat_hit = 1'b0;
		acc = scale_sat(c5, 5);
		acc = add_sat(scale_sat(c4, 4), mul_fx(acc, t));
		acc = add_sat(scale_sat(c3, 3), mul_fx(acc, t));
		acc = add_sat(2 * longint'(half_acc), mul_fx(acc, t));
		acc = add_sat(longint'(v_start), mul_fx(acc, t));
		if (acc > 64'sh7fff_ffff) begin
			acc = 64'sh7fff_ffff;
			sat_hit = 1'b1;
		end else if (acc < -64'sh8000_0000) begin
			acc = -64'sh8000_0000;
			sat_hit = 1'b1;
		end
		res.kind     = qsvp_pkg::KIND_SAMPLE;
		res.velocity = acc[31:0];
		res.steps    = '0;
		res.period   = '0;
		res.compare  = '0;
		res.sat      = sat_hit;
		return res;
	endfunction

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		$display("[%0t] result mismatch on %s: got %h, expected %h", $time, field, got, want);
		fail_count++;
	endtask

	assign pending = result_q.size();

	always @(posedge clk or negedge arst_n) begin
		plan_result_t exp_r;
		if (!arst_n) begin
			rate_hz     <= 32'd1000000;
			vel_floor   <= 32'd65536;
			v_start     = 0;
			half_acc    = 0;
			v_end       = 0;
			acc_end     = 0;
			c3          = 0;
			c4          = 0;
			c5          = 0;
			fail_count  = 0;
			n_segments  = 0;
			n_samples   = 0;
			n_saturated = 0;
			result_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == qsvp_pkg::REG_TIMER_RATE)
					rate_hz <= cfg_data;
				else
					vel_floor <= cfg_data;
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == qsvp_pkg::KIND_SEGMENT) begin
					exp_r = plan_segment(s_tdata);
					n_segments++;
				end else begin
					exp_r = eval_velocity(s_tdata[191:160]);
					n_samples++;
				end
				if (exp_r.sat)
					n_saturated++;
				result_q.push_back(exp_r);
			end
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					$display("[%0t] result transfer with nothing expected", $time);
					fail_count++;
				end else begin
					exp_r = result_q.pop_front();
					if (m_tuser[0] !== exp_r.kind)
						report("result_kind", m_tuser, exp_r.kind);
					if (m_tdata[31:0] !== exp_r.velocity)
						report("velocity", m_tdata[31:0], exp_r.velocity);
					if (m_tdata[63:32] !== exp_r.steps)
						report("step_count", m_tdata[63:32], exp_r.steps);
					if (m_tdata[95:64] !== exp_r.period)
						report("timer_period", m_tdata[95:64], exp_r.period);
					if (m_tdata[126:96] !== exp_r.compare)
						report("timer_compare", m_tdata[126:96], exp_r.compare);
					if (m_tdata[127] !== exp_r.sat)
						report("overflow", m_tdata[127], exp_r.sat);
				end
			end
		end
	end

endmodule

FILE: sim/tb_top.sv
// Stimulus and verdict for the quintic segment velocity planner.
`timescale 1ns / 100ps

module tb_top;

	// generous: every item a full segment fit, plus stalls on both sides
	localparam int CYCLE_LIMIT  = 12_000_000;
	// longer than one segment fit takes; used when draining
	localparam int DRAIN_CYCLES = 1800;
	localparam int RANDOM_ITEMS = 1730;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid, s_tready;
	logic [191:0] s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid, m_tready;
	logic [127:0] m_tdata;
	logic [0:0]   m_tuser;
	logic         cfg_valid, cfg_ready;
	logic [0:0]   cfg_index;
	logic [31:0]  cfg_data;

	int fail_count, pending, n_segments, n_samples, n_saturated;
	logic idle_on;
	int   stall_left;
	longint cycles;

	quintic_segment_velocity_planner_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	qsvp_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending),
		.n_segments  (n_segments),
		.n_samples   (n_samples),
		.n_saturated (n_saturated)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Stall the result side in short bursts while idling is on.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 3);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// End the run if the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("[quintic_segment_velocity_planner_core] ERROR");
			$finish;
		end
	end

	// Transfer one item. Valid stays high between back-to-back items and drops only
	// for an idle burst.
	task automatic send_item(logic kind, logic [31:0] cur, logic [31:0] tgt,
			logic [31:0] vel, logic [31:0] acc, logic [31:0] dur, logic [31:0] ts);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {ts, dur, acc, vel, tgt, cur};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_segment(logic [31:0] cur, logic [31:0] tgt, logic [31:0] vel,
			logic [31:0] acc, logic [31:0] dur);
		send_item(qsvp_pkg::KIND_SEGMENT, cur, tgt, vel, acc, dur, $urandom);
	endtask

	task automatic send_sample(logic [31:0] ts);
		send_item(qsvp_pkg::KIND_SAMPLE, $urandom, $urandom, $urandom, $urandom, $urandom,
			ts);
	endtask

	// Drain every outstanding result, then let the datapath settle before a write.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(qsvp_pkg::reg_index_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_timer(logic [31:0] rate, logic [31:0] floor_v);
		wait_idle();
		write_reg(qsvp_pkg::REG_TIMER_RATE, rate);
		write_reg(qsvp_pkg::REG_MIN_VELOCITY, floor_v);
	endtask

	// Mostly moderate values, sometimes anything at all so every bit toggles.
	function automatic logic [31:0] pick_q(int span);
		logic [31:0] v;
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		v = $urandom_range(0, span);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	function automatic logic [31:0] pick_duration();
		case ($urandom_range(0, 9))
			0:       return $urandom;
			1:       return $urandom_range(0, 16);
			default: return $urandom_range(32'h0000_4000, 32'h0008_0000);
		endcase
	endfunction

	// One segment followed by a few samples inside it, sometimes beyond it.
	task automatic send_profile(output int n_sent);
		logic [31:0] dur, cur;
		int          n_smp;
		dur = pick_duration();
		cur = pick_q(1_000_000);
		n_smp = $urandom_range(1, 4);
		send_segment(cur, cur + pick_q(200_000), pick_q(32'h0100_0000),
			pick_q(32'h0040_0000), dur);
		repeat (n_smp) begin
			if ($urandom_range(0, 5) == 0)
				send_sample($urandom);
			else
				send_sample($urandom_range(0, dur));
		end
		n_sent = 1 + n_smp;
	endtask

	initial begin
		int sent;
		int phase;
		int n;
		logic [31:0] rates[6];
		logic [31:0] floors[6];
		rates  = '{32'd1000000, 32'd1, 32'hffff_ffff, 32'd0, 32'hffff_ffff, 32'd48000};
		floors = '{32'd65536, 32'd1, 32'hffff_ffff, 32'd0, 32'd1, 32'h0001_8000};

		arst_n    = 1'b0;
		cycles    = 0;
		idle_on   = 1'b1;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = qsvp_pkg::KIND_SEGMENT;
		cfg_valid = 1'b0;
		cfg_index = qsvp_pkg::REG_TIMER_RATE;
		cfg_data  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: samples from the reset state, field extremes, duration of zero,
		// one and the largest, saturated fits and samples at both ends of time.
		send_sample(32'd0);
		send_sample(32'hffff_ffff);
		send_segment(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_segment(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1);
		send_sample(32'd0);
		send_sample(32'hffff_ffff);
		send_sample(32'h0001_0000);
		send_segment(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'hffff_ffff);
		send_sample(32'h8000_0000);
		send_segment(32'd100, 32'd100, 32'h0002_0000, 32'hffff_0000, 32'hffff_ffff);
		send_sample(32'h7fff_ffff);
		send_segment(32'd0, 32'd4000, 32'h0010_0000, 32'd0, 32'h0002_0000);
		send_sample(32'h0001_0000);
		send_segment(32'd4000, 32'd0, 32'hfff0_0000, 32'h0008_0000, 32'h0000_8000);
		send_sample(32'h0000_4000);
		send_segment(32'hffff_fff0, 32'h10, 32'h0000_0001, 32'hffff_ffff, 32'd0);
		send_sample(32'd1);

		// Random: one phase per timer setting, idle-free stretch at the very end.
		sent = 0;
		for (phase = 0; phase < 6; phase++) begin
			set_timer(rates[phase], floors[phase]);
			while (sent < (phase + 1) * RANDOM_ITEMS / 6) begin
				if (phase == 5 && sent > RANDOM_ITEMS - 200)
					idle_on = 1'b0;
				if ($urandom_range(0, 9) == 0) begin
					send_item($urandom_range(0, 1), $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom);
					sent++;
				end else begin
					send_profile(n);
					sent += n;
				end
			end
		end

		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d segment fits and %0d velocity samples, %0d of them saturating",
			n_segments, n_samples, n_saturated);
		$display("timer settings included zero and full-scale rate and minimum velocity");
		if (fail_count == 0)
			$display("[quintic_segment_velocity_planner_core] OK");
		else
			$display("[quintic_segment_velocity_planner_core] ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/qsvp_pkg.sv
hdl/qsvp_serial_div.sv
hdl/qsvp_serial_mul.sv
hdl/quintic_segment_velocity_planner_core.sv
sim/qsvp_checker.sv
sim/tb_top.sv
